[rtl/pfc_pkg.sv]
// Shared types, constants and square arithmetic for the 5x5 digraph cipher.
// No dependencies; the top level, front end and engine refer to it by scoped names.
`default_nettype none

package pfc_pkg;

  // Input mode codes
  localparam logic [2:0] MODE_KEY     = 3'd0;
  localparam logic [2:0] MODE_KEY_END = 3'd1;
  localparam logic [2:0] MODE_ENC     = 3'd2;
  localparam logic [2:0] MODE_DEC     = 3'd3;
  localparam logic [2:0] MODE_END     = 3'd4;

  // Letters and square geometry
  localparam logic [4:0] LETTER_I    = 5'd8;
  localparam logic [4:0] LETTER_J    = 5'd9;
  localparam logic [4:0] LETTER_X    = 5'd23;
  localparam logic [4:0] LETTER_LAST = 5'd25;
  localparam int         LETTERS     = 26;
  localparam int         CELLS       = 25;
  localparam logic [4:0] CELLS_FULL  = 5'd25;
  localparam logic [2:0] SIDE_LAST   = 3'd4;

  // Commands from the front end to the engine
  typedef enum logic [1:0] {
    OP_PLACE,
    OP_KEY_END,
    OP_MAP
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] a;    // letter to place, or first letter of a pair
    logic [4:0] b;    // second letter of a pair
    logic       dec;  // pair is deciphered
  } cmd_t;

  // One result word
  typedef struct packed {
    logic [4:0] letter;
    logic       second;
  } out_t;

  // Engine states
  typedef enum logic [2:0] {
    B_IDLE,
    B_POS_B,
    B_CALC,
    B_SQ1,
    B_SQ2,
    B_WALK
  } bstate_t;

  // Row of a cell index 0..24
  function automatic logic [2:0] row_of(logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20)      r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5)  r = 3'd1;
    else                 r = 3'd0;
    return r;
  endfunction

  // Cell index from row and column: r*5 + c
  function automatic logic [4:0] cell_at(logic [2:0] r, logic [2:0] c);
    return {r, 2'b00} + {2'b00, r} + {2'b00, c};
  endfunction

  // Column of a cell index 0..24
  function automatic logic [2:0] col_of(logic [4:0] p);
    logic [4:0] d;
    d = p - cell_at(row_of(p), 3'd0);
    return d[2:0];
  endfunction

  // Step one place around a row or column: forward to encipher, back to decipher
  function automatic logic [2:0] wrap_step(logic [2:0] v, logic dec);
    logic [2:0] s;
    if (dec) s = (v == 3'd0) ? SIDE_LAST : v - 3'd1;
    else     s = (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    return s;
  endfunction

  // Mapped cell of the letter at pa, paired with the letter at pb
  function automatic logic [4:0] map_cell(logic [4:0] pa, logic [4:0] pb, logic dec);
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] n;
    ra = row_of(pa);
    ca = col_of(pa);
    rb = row_of(pb);
    cb = col_of(pb);
    if (ra == rb)      n = cell_at(ra, wrap_step(ca, dec));
    else if (ca == cb) n = cell_at(wrap_step(ra, dec), ca);
    else               n = cell_at(ra, cb);
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/playfair_digraph_cipher.sv]
// Playfair digraph cipher on a 5x5 square: top level.
// Input side is a queue: present mode and letter with push; a word is taken
// at a rising edge where push is high and full is low. Result side is a
// queue: while empty is low, out_letter and pair_second show the oldest
// result; it is taken at a rising edge where pop is high and empty is low.
// Each digraph gives two results, the second marked by pair_second.
// A front end forms digraphs and queues commands (CMD_DEPTH deep); an engine
// runs them one at a time against two small RAMs (square and letter cells).
// Key letter: placed, if new and the square has room, as its command is taken.
// Key end: the command is taken, then each alphabet letter but j is offered.
// Digraph: four serial reads on the single read port of each RAM, the cells
// of both letters from the position RAM, then the two mapped letters from
// the square RAM; results go into the result queue (OUT_DEPTH deep).
// The front end turns each input word into a command combinationally.
// A stalled receiver fills the result queue; the engine then waits before a
// new digraph and the command queue fills, raising full.
// Synchronous reset clears the queues, the pending letter, the fill count and
// the used-letter marks; the square contents are meaningless until keyed.
// Depends on pfc_pkg, pfc_fifo, pfc_front, pfc_back and pfc_ram.
`default_nettype none

module playfair_digraph_cipher #(
  parameter int CMD_DEPTH = 4,
  parameter int OUT_DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [2:0] mode,
  input  wire logic [4:0] letter,
  output logic            empty,
  input  wire logic       pop,
  output logic      [4:0] out_letter,
  output logic            pair_second
);

  logic          accept;
  logic          cmd_push;
  pfc_pkg::cmd_t cmd_in;
  pfc_pkg::cmd_t cmd_out;
  logic          cmd_empty;
  logic          cmd_pop;
  logic          cmd_room2;
  logic          out_push;
  logic          out_room2;
  logic          out_full;
  pfc_pkg::out_t out_in;
  pfc_pkg::out_t out_head;

  assign accept = push && !full;

  // Classify words and form digraphs
  pfc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .mode     (mode),
    .letter   (letter),
    .cmd_push (cmd_push),
    .cmd      (cmd_in)
  );

  // Queue commands between front end and engine
  pfc_fifo #(.WIDTH($bits(pfc_pkg::cmd_t)), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_out),
    .empty (cmd_empty),
    .room2 (cmd_room2)
  );

  // Key the square and map digraphs
  pfc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .out_room2 (out_room2),
    .out_push  (out_push),
    .out_word  (out_in)
  );

  // Queue result words for the receiver
  pfc_fifo #(.WIDTH($bits(pfc_pkg::out_t)), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (out_push),
    .din   (out_in),
    .full  (out_full),
    .pop   (pop),
    .dout  (out_head),
    .empty (empty),
    .room2 (out_room2)
  );

  assign out_letter  = out_head.letter;
  assign pair_second = out_head.second;

endmodule

`default_nettype wire

[rtl/pfc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pfc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/pfc_fifo.sv]
// Small register-based FIFO used for the command queue and the result queue.
// No dependencies.
`default_nettype none

module pfc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] din,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] dout,
  output logic                  empty,
  output logic                  room2
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  assign dout  = mem[rd_ptr];
  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign room2 = (count <= CW'(DEPTH - 2));

endmodule

`default_nettype wire

[rtl/pfc_front.sv]
// Front end: classifies each input word, folds j into i, forms digraphs
// and emits commands for the engine. Depends on pfc_pkg.
`default_nettype none

module pfc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          accept,
  input  wire logic [2:0]    mode,
  input  wire logic [4:0]    letter,
  output logic               cmd_push,
  output pfc_pkg::cmd_t      cmd
);

  logic       pending_valid;
  logic       pending_decrypt;
  logic [4:0] pending_letter;
  logic       pending_valid_next;
  logic       pending_decrypt_next;
  logic [4:0] pending_letter_next;
  logic [4:0] folded;
  logic       in_range;

  assign folded   = (letter == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : letter;
  assign in_range = (letter <= pfc_pkg::LETTER_LAST);

  // Decode the word into a command and the next pending letter
  always_comb begin
    cmd_push             = 1'b0;
    cmd.op               = pfc_pkg::OP_PLACE;
    cmd.a                = folded;
    cmd.b                = pfc_pkg::LETTER_X;
    cmd.dec              = 1'b0;
    pending_valid_next   = pending_valid;
    pending_decrypt_next = pending_decrypt;
    pending_letter_next  = pending_letter;
    if (accept) begin
      unique case (mode)
        pfc_pkg::MODE_KEY: begin
          cmd_push = in_range;
        end
        pfc_pkg::MODE_KEY_END: begin
          cmd_push = 1'b1;
          cmd.op   = pfc_pkg::OP_KEY_END;
        end
        pfc_pkg::MODE_END: begin
          // Pad an odd plaintext letter with x; drop a lone cipher letter
          pending_valid_next   = 1'b0;
          pending_decrypt_next = 1'b0;
          cmd_push             = pending_valid && !pending_decrypt;
          cmd.op               = pfc_pkg::OP_MAP;
          cmd.a                = pending_letter;
        end
        pfc_pkg::MODE_ENC, pfc_pkg::MODE_DEC: begin
          if (in_range) begin
            if (!pending_valid) begin
              pending_valid_next   = 1'b1;
              pending_letter_next  = folded;
              pending_decrypt_next = (mode == pfc_pkg::MODE_DEC);
            end else if (mode == pfc_pkg::MODE_DEC) begin
              pending_valid_next   = 1'b0;
              pending_decrypt_next = 1'b0;
              cmd_push             = 1'b1;
              cmd.op               = pfc_pkg::OP_MAP;
              cmd.a                = pending_letter;
              cmd.b                = folded;
              cmd.dec              = 1'b1;
            end else if (pending_letter == folded) begin
              // Doubled letter: pad with x and keep the letter pending
              pending_decrypt_next = 1'b0;
              cmd_push             = 1'b1;
              cmd.op               = pfc_pkg::OP_MAP;
              cmd.a                = folded;
            end else begin
              pending_valid_next   = 1'b0;
              pending_decrypt_next = 1'b0;
              cmd_push             = 1'b1;
              cmd.op               = pfc_pkg::OP_MAP;
              cmd.a                = pending_letter;
              cmd.b                = folded;
            end
          end
        end
        default: begin
          cmd_push = 1'b0;
        end
      endcase
    end
  end

  // Hold the pending letter
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid   <= 1'b0;
      pending_decrypt <= 1'b0;
      pending_letter  <= '0;
    end else begin
      pending_valid   <= pending_valid_next;
      pending_decrypt <= pending_decrypt_next;
      pending_letter  <= pending_letter_next;
    end
  end

endmodule

`default_nettype wire

[rtl/pfc_back.sv]
// Engine: fills the key square and maps digraphs through it, one command
// at a time. Depends on pfc_pkg and pfc_ram.
`default_nettype none

module pfc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cmd_valid,
  input  wire pfc_pkg::cmd_t cmd,
  output logic               cmd_pop,
  input  wire logic          out_room2,
  output logic               out_push,
  output pfc_pkg::out_t      out_word
);

  pfc_pkg::bstate_t       state;
  pfc_pkg::bstate_t       state_next;
  pfc_pkg::cmd_t          cur;
  logic [4:0]             pa;
  logic [4:0]             n2;
  logic [4:0]             walk;
  logic [4:0]             fill_count;
  logic [pfc_pkg::LETTERS-1:0] used;

  logic                   place_en;
  logic [4:0]             place_letter;
  logic                   do_place;
  logic [4:0]             pos_raddr;
  logic [4:0]             pos_rdata;
  logic [4:0]             sq_raddr;
  logic [4:0]             sq_rdata;

  // Letter at each cell of the square
  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::CELLS)) u_square (
    .clk   (clk),
    .we    (do_place),
    .waddr (fill_count),
    .wdata (place_letter),
    .raddr (sq_raddr),
    .rdata (sq_rdata)
  );

  // Cell of each letter
  pfc_ram #(.WIDTH(5), .DEPTH(pfc_pkg::LETTERS)) u_position (
    .clk   (clk),
    .we    (do_place),
    .waddr (place_letter),
    .wdata (fill_count),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign do_place = place_en && (fill_count < pfc_pkg::CELLS_FULL) && !used[place_letter];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pfc_pkg::B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            pfc_pkg::OP_KEY_END: state_next = pfc_pkg::B_WALK;
            pfc_pkg::OP_MAP:     state_next = out_room2 ? pfc_pkg::B_POS_B : pfc_pkg::B_IDLE;
            default:             state_next = pfc_pkg::B_IDLE;
          endcase
        end
      end
      pfc_pkg::B_POS_B: state_next = pfc_pkg::B_CALC;
      pfc_pkg::B_CALC:  state_next = pfc_pkg::B_SQ1;
      pfc_pkg::B_SQ1:   state_next = pfc_pkg::B_SQ2;
      pfc_pkg::B_SQ2:   state_next = pfc_pkg::B_IDLE;
      pfc_pkg::B_WALK: begin
        if (walk == pfc_pkg::LETTER_LAST) state_next = pfc_pkg::B_IDLE;
      end
      default: state_next = pfc_pkg::B_IDLE;
    endcase
  end

  // Outputs: command pop, square updates, lookups, result words
  always_comb begin
    cmd_pop         = 1'b0;
    place_en        = 1'b0;
    place_letter    = cmd.a;
    pos_raddr       = cur.a;
    sq_raddr        = n2;
    out_push        = 1'b0;
    out_word.letter = sq_rdata;
    out_word.second = 1'b0;
    unique case (state)
      pfc_pkg::B_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            pfc_pkg::OP_PLACE: begin
              cmd_pop  = 1'b1;
              place_en = 1'b1;
            end
            pfc_pkg::OP_KEY_END: begin
              cmd_pop = 1'b1;
            end
            pfc_pkg::OP_MAP: begin
              cmd_pop   = out_room2;
              pos_raddr = cmd.a;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      pfc_pkg::B_POS_B: begin
        pos_raddr = cur.b;
      end
      pfc_pkg::B_CALC: begin
        sq_raddr = pfc_pkg::map_cell(pa, pos_rdata, cur.dec);
      end
      pfc_pkg::B_SQ1: begin
        out_push = 1'b1;
      end
      pfc_pkg::B_SQ2: begin
        out_push        = 1'b1;
        out_word.second = 1'b1;
      end
      pfc_pkg::B_WALK: begin
        place_letter = walk;
        place_en     = (walk != pfc_pkg::LETTER_J);
      end
      default: begin
        out_push = 1'b0;
      end
    endcase
  end

  // Control state: FSM, fill count, used marks, alphabet walk
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pfc_pkg::B_IDLE;
      fill_count <= '0;
      used       <= '0;
      walk       <= '0;
    end else begin
      state <= state_next;
      if (do_place) begin
        used[place_letter] <= 1'b1;
        fill_count         <= fill_count + 5'd1;
      end
      if (state == pfc_pkg::B_WALK) walk <= walk + 5'd1;
      else                          walk <= '0;
    end
  end

  // Hold the pair and intermediate cells
  always_ff @(posedge clk) begin
    if (state == pfc_pkg::B_IDLE && cmd_pop) begin
      cur <= cmd;
    end
    if (state == pfc_pkg::B_POS_B) begin
      pa <= pos_rdata;
    end
    if (state == pfc_pkg::B_CALC) begin
      n2 <= pfc_pkg::map_cell(pos_rdata, pa, cur.dec);
    end
  end

endmodule

`default_nettype wire
